### sv/dtq_pkg.sv
package dtq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;
  localparam int MAX_RESULTS     = 16;

  localparam logic [63:0] QUANTUM_RESET = 64'd10000000;

  localparam logic [1:0] CFG_QUANTUM   = 2'd0;
  localparam logic [1:0] CFG_MIN_DELTA = 2'd1;
  localparam logic [1:0] CFG_MAX_DELTA = 2'd2;

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_CANCEL,
    MODE_EXPIRE,
    MODE_ARM
  } mode_t;

  typedef enum logic [2:0] {
    KIND_INSERTED,
    KIND_REJECTED,
    KIND_CANCELLED,
    KIND_CANCEL_MISS,
    KIND_EXPIRED,
    KIND_NONE_EXPIRED,
    KIND_ARMED,
    KIND_NOT_ARMED
  } kind_t;

  typedef enum logic [2:0] {
    ARM_NONE,
    ARM_TGT,
    ARM_SEL,
    ARM_DELTA,
    ARM_MIN,
    ARM_MAX
  } arm_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_INSERT,
    ST_CANCEL,
    ST_EXPIRE,
    ST_ARM_TGT,
    ST_ARM_SEL,
    ST_ARM_DELTA,
    ST_ARM_MIN,
    ST_ARM_MAX,
    ST_ARM_OUT,
    ST_NO_ARM
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    ins;
    logic    rem;
    logic    rem_head;
    logic    emit;
    kind_t   kind;
    logic    last;
    arm_op_t arm;
  } dtq_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  idle_next;
    logic  scan_done;
    logic  found;
    logic  full;
    logic  time_zero;
    logic  empty;
    logic  head_due;
    logic  more_due;
    logic  out_free;
  } dtq_sts_t;

endpackage

### sv/dtq_ctrl.sv
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dtq_sts_t sts,
  output dtq_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.kind     = KIND_INSERTED;
    cmd.arm      = ARM_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.mode)
          MODE_INSERT, MODE_CANCEL: state_nxt = ST_SCAN;
          MODE_EXPIRE:              state_nxt = ST_EXPIRE;
          MODE_ARM:                 state_nxt = ST_ARM_TGT;
        endcase
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = (sts.mode == MODE_INSERT) ? ST_INSERT : ST_CANCEL;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_INSERT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
          if (sts.full || sts.time_zero || sts.found) begin
            cmd.kind = KIND_REJECTED;
          end else begin
            cmd.kind = KIND_INSERTED;
            cmd.ins  = 1'b1;
          end
        end
      end
      ST_CANCEL: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
          if (sts.found) begin
            cmd.kind = KIND_CANCELLED;
            cmd.rem  = 1'b1;
          end else begin
            cmd.kind = KIND_CANCEL_MISS;
          end
        end
      end
      ST_EXPIRE: begin
        // pop one due head per result until the burst ends
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.head_due) begin
            cmd.kind     = KIND_EXPIRED;
            cmd.rem      = 1'b1;
            cmd.rem_head = 1'b1;
            cmd.last     = !sts.more_due;
            if (!sts.more_due) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.kind  = KIND_NONE_EXPIRED;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ARM_TGT: begin
        if (sts.idle_next && sts.empty) begin
          state_nxt = ST_NO_ARM;
        end else begin
          cmd.arm   = ARM_TGT;
          state_nxt = ST_ARM_SEL;
        end
      end
      ST_ARM_SEL: begin
        cmd.arm   = ARM_SEL;
        state_nxt = ST_ARM_DELTA;
      end
      ST_ARM_DELTA: begin
        cmd.arm   = ARM_DELTA;
        state_nxt = ST_ARM_MIN;
      end
      ST_ARM_MIN: begin
        cmd.arm   = ARM_MIN;
        state_nxt = ST_ARM_MAX;
      end
      ST_ARM_MAX: begin
        cmd.arm   = ARM_MAX;
        state_nxt = ST_ARM_OUT;
      end
      ST_ARM_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_ARMED;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_NO_ARM: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = KIND_NOT_ARMED;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/dtq_dpath.sv
module dtq_dpath
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic [1:0]         in_mode,
  input  logic [ID_BITS-1:0] in_thread_id,
  input  logic [63:0]        in_time_ns,
  input  logic               in_next_is_idle,
  output logic               out_valid,
  input  logic               out_ready,
  output kind_t              out_kind,
  output logic [ID_BITS-1:0] out_woken_id,
  output logic [63:0]        out_deadline_ns,
  output logic [63:0]        out_delta_ns,
  output logic               out_last,
  input  dtq_cmd_t           cmd,
  output dtq_sts_t           sts
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  // transaction held for the whole operation
  mode_t              mode_r;
  logic [ID_BITS-1:0] tid_r;
  logic [63:0]        time_r;
  logic               idle_r;

  logic [63:0] quantum_r, min_r, max_r;

  logic [63:0]        ent_dl_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0] ent_id_r [QUEUE_DEPTH];
  logic [63:0]        dl_nxt   [QUEUE_DEPTH];
  logic [ID_BITS-1:0] id_nxt   [QUEUE_DEPTH];
  logic [CW-1:0]      cnt_r;

  logic [CW-1:0] idx_r;
  logic [AW-1:0] sidx;
  logic          found_r;
  logic [AW-1:0] fpos_r;
  logic [63:0]   hit_dl_r;
  logic          pos_ok_r;
  logic [CW-1:0] ipos_r;
  logic [CW-1:0] rpos;
  logic [NW-1:0] burst_r;

  logic [63:0] qd_r, tgt_r, delta_r;
  logic [64:0] sum;
  logic [63:0] sum_sat;
  logic [64:0] diff;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [63:0]        out_dl_r, out_delta_r;
  logic               out_last_r;
  logic [ID_BITS-1:0] res_id;
  logic [63:0]        res_dl, res_delta;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      tid_r  <= in_thread_id;
      time_r <= in_time_ns;
      idle_r <= in_next_is_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
      min_r     <= '0;
      max_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUANTUM:   quantum_r <= cfg_wdata;
        CFG_MIN_DELTA: min_r     <= cfg_wdata;
        CFG_MAX_DELTA: max_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sidx = idx_r[AW-1:0];
  assign rpos = cmd.rem_head ? '0 : CW'(fpos_r);

  // sorted shift queue: insert opens a slot, remove closes one
  always_comb begin
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      dl_nxt[j] = ent_dl_r[j];
      id_nxt[j] = ent_id_r[j];
      if (cmd.ins && CW'(j) == ipos_r) begin
        dl_nxt[j] = time_r;
        id_nxt[j] = tid_r;
      end else if (cmd.ins && CW'(j) > ipos_r && CW'(j) <= cnt_r) begin
        dl_nxt[j] = ent_dl_r[(j > 0) ? j - 1 : 0];
        id_nxt[j] = ent_id_r[(j > 0) ? j - 1 : 0];
      end else if (cmd.rem && CW'(j) >= rpos && CW'(j + 1) < cnt_r) begin
        dl_nxt[j] = ent_dl_r[(j < QUEUE_DEPTH - 1) ? j + 1 : j];
        id_nxt[j] = ent_id_r[(j < QUEUE_DEPTH - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_dl_r <= dl_nxt;
    ent_id_r <= id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ins) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.rem) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // linear walk: duplicate / cancel match and first later deadline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      found_r  <= 1'b0;
      pos_ok_r <= 1'b0;
      burst_r  <= '0;
    end else if (cmd.load) begin
      idx_r    <= '0;
      found_r  <= 1'b0;
      pos_ok_r <= 1'b0;
      ipos_r   <= cnt_r;
      burst_r  <= '0;
    end else begin
      if (cmd.scan) begin
        idx_r <= idx_r + CW'(1);
        if (!found_r && ent_id_r[sidx] == tid_r) begin
          found_r  <= 1'b1;
          fpos_r   <= sidx;
          hit_dl_r <= ent_dl_r[sidx];
        end
        if (!pos_ok_r && ent_dl_r[sidx] > time_r) begin
          pos_ok_r <= 1'b1;
          ipos_r   <= idx_r;
        end
      end
      if (cmd.rem && cmd.rem_head) begin
        burst_r <= burst_r + NW'(1);
      end
    end
  end

  assign sum     = {1'b0, time_r} + {1'b0, quantum_r};
  assign sum_sat = sum[64] ? '1 : sum[63:0];
  assign diff    = {1'b0, tgt_r} - {1'b0, time_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_r <= '0;
    end else if (cmd.arm == ARM_TGT && !idle_r) begin
      qd_r <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.arm)
      ARM_TGT: begin
        if (idle_r) begin
          tgt_r <= ent_dl_r[0];
        end
      end
      ARM_SEL: begin
        if (!idle_r) begin
          tgt_r <= (cnt_r != '0 && ent_dl_r[0] < qd_r) ? ent_dl_r[0] : qd_r;
        end
      end
      ARM_DELTA: begin
        // deadline at or before now gives the smallest delta
        delta_r <= (diff[64] || diff[63:0] == '0) ? 64'd1 : diff[63:0];
      end
      ARM_MIN: begin
        if (min_r != '0 && delta_r < min_r) begin
          delta_r <= min_r;
        end
      end
      ARM_MAX: begin
        if (max_r != '0 && delta_r > max_r) begin
          delta_r <= max_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_id    = '0;
    res_dl    = '0;
    res_delta = '0;
    unique case (cmd.kind)
      KIND_INSERTED, KIND_REJECTED: begin
        res_id = tid_r;
        res_dl = time_r;
      end
      KIND_CANCELLED: begin
        res_id = tid_r;
        res_dl = hit_dl_r;
      end
      KIND_CANCEL_MISS: begin
        res_id = tid_r;
      end
      KIND_EXPIRED: begin
        res_id = ent_id_r[0];
        res_dl = ent_dl_r[0];
      end
      KIND_ARMED: begin
        res_dl    = tgt_r;
        res_delta = delta_r;
      end
      KIND_NONE_EXPIRED, KIND_NOT_ARMED: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= cmd.kind;
      out_id_r    <= res_id;
      out_dl_r    <= res_dl;
      out_delta_r <= res_delta;
      out_last_r  <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_woken_id    = out_id_r;
  assign out_deadline_ns = out_dl_r;
  assign out_delta_ns    = out_delta_r;
  assign out_last        = out_last_r;

  assign sts.mode      = mode_r;
  assign sts.idle_next = idle_r;
  assign sts.scan_done = (idx_r == cnt_r);
  assign sts.found     = found_r;
  assign sts.full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign sts.time_zero = (time_r == '0);
  assign sts.empty     = (cnt_r == '0);
  assign sts.head_due  = (cnt_r != '0) && (ent_dl_r[0] <= time_r);
  assign sts.more_due  = (cnt_r > CW'(1)) && (ent_dl_r[1] <= time_r) &&
                         (burst_r < NW'(MAX_RESULTS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

### sv/deadline_timeout_queue.sv
// channel  direction  handshake             payload
// cfg      in         cfg_we                cfg_index, cfg_wdata
// in       in         in_valid / in_ready   in_mode, in_thread_id, in_time_ns, in_next_is_idle
// out      out        out_valid / out_ready out_kind, out_woken_id, out_deadline_ns,
//                                           out_delta_ns, out_last
//
// insert and cancel walk the queue one entry per cycle
// expire gives one result per cycle while out_ready is high
// arm runs a five-step add / compare / clamp sequence, skipped when not armed
// reset (rst_n low, synchronous) empties the queue and loads the default config
// out_ready low holds the result register; the next transaction is still taken
// and stalls only when it needs to emit
module deadline_timeout_queue
  import dtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [ID_BITS-1:0] in_thread_id,
  input  logic [63:0]        in_time_ns,
  input  logic               in_next_is_idle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [ID_BITS-1:0] out_woken_id,
  output logic [63:0]        out_deadline_ns,
  output logic [63:0]        out_delta_ns,
  output logic               out_last
);

  dtq_cmd_t cmd;
  dtq_sts_t sts;
  kind_t    kind;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_mode),
    .in_thread_id    (in_thread_id),
    .in_time_ns      (in_time_ns),
    .in_next_is_idle (in_next_is_idle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (kind),
    .out_woken_id    (out_woken_id),
    .out_deadline_ns (out_deadline_ns),
    .out_delta_ns    (out_delta_ns),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

  assign out_kind = kind;

`ifndef SYNTH
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result emitted while output register still occupied");

  a_insert_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> (!sts.full && !sts.found && !sts.time_zero))
    else $error("insert applied to full queue or duplicate id");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |-> !sts.empty)
    else $error("remove from empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("controller stayed idle after accepting a transaction");
`endif

endmodule

### tb/timeout_queue_checker.sv
`timescale 1ns / 100ps

module timeout_queue_checker
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_thread_id,
  input  logic [63:0] in_time_ns,
  input  logic        in_next_is_idle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_woken_id,
  input  logic [63:0] out_deadline_ns,
  input  logic [63:0] out_delta_ns,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int          SLOTS    = DEF_QUEUE_DEPTH;
  localparam logic [63:0] TIME_MAX = '1;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  woken;
    logic [63:0] deadline;
    logic [63:0] delta;
    logic        last;
  } outcome_t;

  outcome_t    awaited[$];
  outcome_t    head;
  logic [63:0] slot_deadline [SLOTS];
  logic [7:0]  slot_thread [SLOTS];
  int          occupancy;
  logic [63:0] quantum;
  logic [63:0] min_delta;
  logic [63:0] max_delta;
  logic [63:0] slice_end;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 40)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  function automatic outcome_t make_outcome(input kind_t k, input logic [7:0] id,
                                            input logic [63:0] dl, input logic [63:0] dt,
                                            input logic fin);
    outcome_t o;
    o.kind     = k;
    o.woken    = id;
    o.deadline = dl;
    o.delta    = dt;
    o.last     = fin;
    return o;
  endfunction

  function automatic int slot_of(input logic [7:0] id);
    int i;
    for (i = 0; i < occupancy; i++)
      if (slot_thread[i] == id) return i;
    return -1;
  endfunction

  task automatic drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < occupancy; i++) begin
      slot_deadline[i] = slot_deadline[i + 1];
      slot_thread[i]   = slot_thread[i + 1];
    end
    occupancy--;
  endtask

  task automatic predict_transaction(input mode_t op, input logic [7:0] id,
                                     input logic [63:0] t, input logic idle);
    int          pos;
    int          due;
    int          i;
    logic [63:0] target;
    logic [63:0] delta;
    case (op)
      MODE_INSERT: begin
        if (occupancy >= SLOTS || t == 64'd0 || slot_of(id) >= 0) begin
          awaited.push_back(make_outcome(KIND_REJECTED, id, t, 64'd0, 1'b1));
        end else begin
          pos = 0;
          // equal deadlines keep arrival order
          while (pos < occupancy && slot_deadline[pos] <= t) pos++;
          for (i = occupancy; i > pos; i--) begin
            slot_deadline[i] = slot_deadline[i - 1];
            slot_thread[i]   = slot_thread[i - 1];
          end
          slot_deadline[pos] = t;
          slot_thread[pos]   = id;
          occupancy++;
          awaited.push_back(make_outcome(KIND_INSERTED, id, t, 64'd0, 1'b1));
        end
      end
      MODE_CANCEL: begin
        pos = slot_of(id);
        if (pos < 0) begin
          awaited.push_back(make_outcome(KIND_CANCEL_MISS, id, 64'd0, 64'd0, 1'b1));
        end else begin
          awaited.push_back(make_outcome(KIND_CANCELLED, id, slot_deadline[pos], 64'd0, 1'b1));
          drop_slot(pos);
        end
      end
      MODE_EXPIRE: begin
        // queue is sorted, so the due entries form a prefix
        due = 0;
        while (due < MAX_RESULTS && due < occupancy && slot_deadline[due] <= t) due++;
        if (due == 0) begin
          awaited.push_back(make_outcome(KIND_NONE_EXPIRED, 8'd0, 64'd0, 64'd0, 1'b1));
        end else begin
          for (i = 0; i < due; i++) begin
            awaited.push_back(make_outcome(KIND_EXPIRED, slot_thread[0], slot_deadline[0],
                                           64'd0, i == due - 1));
            drop_slot(0);
          end
        end
      end
      MODE_ARM: begin
        if (idle && occupancy == 0) begin
          awaited.push_back(make_outcome(KIND_NOT_ARMED, 8'd0, 64'd0, 64'd0, 1'b1));
        end else begin
          if (idle) begin
            target = slot_deadline[0];
          end else begin
            slice_end = (t > TIME_MAX - quantum) ? TIME_MAX : t + quantum;
            target = slice_end;
            if (occupancy > 0 && slot_deadline[0] < target) target = slot_deadline[0];
          end
          delta = (target > t) ? target - t : 64'd1;
          // min first, then max, so max wins when they cross
          if (min_delta != 64'd0 && delta < min_delta) delta = min_delta;
          if (max_delta != 64'd0 && delta > max_delta) delta = max_delta;
          awaited.push_back(make_outcome(KIND_ARMED, 8'd0, target, delta, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited.delete();
      occupancy = 0;
      quantum   = QUANTUM_RESET;
      min_delta = 64'd0;
      max_delta = 64'd0;
      slice_end = 64'd0;
      errors    = 0;
      checked   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM:   quantum   = cfg_wdata;
          CFG_MIN_DELTA: min_delta = cfg_wdata;
          CFG_MAX_DELTA: max_delta = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        checked++;
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result, kind", 64'(out_kind), 64'd0);
        end else begin
          head = awaited.pop_front();
          if (out_kind !== head.kind)
            report_mismatch("kind", 64'(out_kind), 64'(head.kind));
          if (out_woken_id !== head.woken)
            report_mismatch("woken_id", 64'(out_woken_id), 64'(head.woken));
          if (out_deadline_ns !== head.deadline)
            report_mismatch("deadline_ns", out_deadline_ns, head.deadline);
          if (out_delta_ns !== head.delta) report_mismatch("delta_ns", out_delta_ns, head.delta);
          if (out_last !== head.last)
            report_mismatch("last", 64'(out_last), 64'(head.last));
        end
      end
      if (in_valid && in_ready)
        predict_transaction(mode_t'(in_mode), in_thread_id, in_time_ns, in_next_is_idle);
    end
    pending = awaited.size();
  end

endmodule

### tb/tb_deadline_timeout_queue.sv
`timescale 1ns / 100ps

module tb_deadline_timeout_queue;
  import dtq_pkg::*;

  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          SETTLE_CYCLES   = 40;
  localparam int          ITEMS_PER_PHASE = 29;
  localparam int          PHASES          = 5;
  localparam logic [1:0]  CFG_UNMAPPED    = 2'd3;
  localparam logic [63:0] TIME_MAX        = '1;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_index       = CFG_QUANTUM;
  logic [63:0] cfg_wdata       = 64'd0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode         = MODE_INSERT;
  logic [7:0]  in_thread_id    = 8'd0;
  logic [63:0] in_time_ns      = 64'd0;
  logic        in_next_is_idle = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_woken_id;
  logic [63:0] out_deadline_ns;
  logic [63:0] out_delta_ns;
  logic        out_last;

  int          mismatches;
  int          awaited_count;
  int          results_seen;
  int          stuck_cycles    = 0;
  int          items_sent      = 0;
  int          directed_items  = 0;
  logic [63:0] now_ns          = 64'd1000;
  logic [15:0] ready_pattern   = 16'hFFFF;
  logic [5:0]  ready_phase     = 6'd0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deadline_timeout_queue dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_mode, .in_thread_id, .in_time_ns, .in_next_is_idle,
    .out_valid, .out_ready, .out_kind, .out_woken_id, .out_deadline_ns, .out_delta_ns,
    .out_last
  );

  timeout_queue_checker u_check (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_mode, .in_thread_id, .in_time_ns, .in_next_is_idle,
    .out_valid, .out_ready, .out_kind, .out_woken_id, .out_deadline_ns, .out_delta_ns,
    .out_last,
    .errors(mismatches), .pending(awaited_count), .checked(results_seen)
  );

  // receiver: rotating ready pattern, reloaded whenever the phase counter wraps, half the time all ready
  always @(negedge clk) begin
    ready_phase <= ready_phase + 6'd1;
    if (ready_phase == 6'd0)
      ready_pattern <= ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                   : 16'($urandom_range(1, 16'hFFFF));
    else
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    out_ready <= ready_pattern[0];
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input mode_t op, input logic [7:0] id, input logic [63:0] t,
                           input logic idle);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_mode         <= op;
    in_thread_id    <= id;
    in_time_ns      <= t;
    in_next_is_idle <= idle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic random_item();
    int          pick;
    int          slant;
    logic [7:0]  id;
    logic [63:0] t;
    pick  = $urandom_range(0, 99);
    slant = $urandom_range(0, 19);
    // a small id pool makes duplicates and cancel hits common
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 23));
    if (pick < 40) begin
      case (slant)
        0:       t = 64'd0;
        1:       t = {$urandom, $urandom};
        default: t = now_ns + 64'($urandom_range(0, 1 << 25));
      endcase
      send_item(MODE_INSERT, id, t, 1'($urandom_range(0, 1)));
    end else if (pick < 60) begin
      send_item(MODE_CANCEL, id, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end else if (pick < 80) begin
      now_ns = now_ns + 64'($urandom_range(0, 1 << 24));
      case (slant)
        0:       t = TIME_MAX;
        1:       t = {$urandom, $urandom};
        default: t = now_ns;
      endcase
      send_item(MODE_EXPIRE, id, t, 1'($urandom_range(0, 1)));
    end else begin
      // looking ahead of now lets some queued deadlines be already past
      case (slant)
        0:       t = TIME_MAX;
        1:       t = {$urandom, $urandom};
        default: t = now_ns + 64'($urandom_range(0, 1 << 24));
      endcase
      send_item(MODE_ARM, id, t, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int burst_left;
    int gap;
    int phase;
    int n;
    int i;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed opening under reset config
    send_item(MODE_ARM,    8'd0,   64'd100,  1'b1);  // idle with empty queue
    send_item(MODE_EXPIRE, 8'd0,   64'd0,    1'b0);  // nothing due
    send_item(MODE_ARM,    8'd0,   64'd200,  1'b0);  // quantum deadline wins
    send_item(MODE_INSERT, 8'd9,   64'd0,    1'b0);  // zero deadline
    send_item(MODE_INSERT, 8'd255, TIME_MAX, 1'b1);
    send_item(MODE_INSERT, 8'd255, 64'd50,   1'b0);  // duplicate id
    send_item(MODE_ARM,    8'd0,   TIME_MAX, 1'b0);  // saturated sum, target not ahead
    send_item(MODE_ARM,    8'd0,   64'd1000, 1'b1);  // head deadline far off
    send_item(MODE_INSERT, 8'd0,   64'd1,    1'b0);
    send_item(MODE_CANCEL, 8'd77,  64'd0,    1'b0);  // absent id
    send_item(MODE_CANCEL, 8'd255, 64'd0,    1'b0);
    for (i = 1; i <= 15; i++) send_item(MODE_INSERT, 8'(i), 64'd5, i[0]);  // equal deadlines
    send_item(MODE_INSERT, 8'd200, 64'd3,    1'b0);  // queue full
    send_item(MODE_EXPIRE, 8'd0,   TIME_MAX, 1'b0);  // whole queue leaves in one burst
    directed_items = items_sent;

    burst_left = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        quiesce();
        case (phase)
          1: begin
            write_reg(CFG_QUANTUM, 64'd1);
            write_reg(CFG_MIN_DELTA, 64'd0);
            write_reg(CFG_MAX_DELTA, 64'd0);
            write_reg(CFG_UNMAPPED, {$urandom, $urandom});
          end
          2: begin
            // zero quantum, min above max
            write_reg(CFG_QUANTUM, 64'd0);
            write_reg(CFG_MIN_DELTA, 64'd5000000);
            write_reg(CFG_MAX_DELTA, 64'd1000000);
          end
          3: begin
            write_reg(CFG_QUANTUM, TIME_MAX);
            write_reg(CFG_MIN_DELTA, TIME_MAX);
            write_reg(CFG_MAX_DELTA, 64'd0);
          end
          default: begin
            write_reg(CFG_QUANTUM, 64'($urandom_range(1, 1 << 24)));
            write_reg(CFG_MIN_DELTA, 64'($urandom_range(1, 1 << 21)));
            write_reg(CFG_MAX_DELTA, 64'($urandom_range(1 << 21, 1 << 23)));
          end
        endcase
        @(negedge clk) cfg_we <= 1'b0;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        random_item();
        burst_left--;
      end
    end

    quiesce();
    $display("covered %0d transactions (%0d directed), %0d results checked, %0d register settings",
             items_sent, directed_items, results_seen, PHASES);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
